// File: rtl/bic_pkg.sv
// bic_pkg: shared types, widths and constants for the box overlap compare unit.
// No dependencies; used by bic_geom, bic_div and box_iou_compare_unit.
package bic_pkg;

  localparam int unsigned COORD_BITS    = 16;
  localparam int unsigned FRACTION_BITS = 16;

  // derived widths
  localparam int unsigned PROD_W  = 2 * COORD_BITS;      // unsigned area / intersection
  localparam int unsigned AREA_W  = 2 * COORD_BITS + 4;  // signed area of box A and union
  localparam int unsigned DEN_W   = 2 * COORD_BITS + 2;  // positive union as divisor
  localparam int unsigned RATIO_W = FRACTION_BITS + 1;

  // pipeline shape
  localparam int unsigned GEOM_STAGES = 5;
  localparam int unsigned DIV_STAGES  = FRACTION_BITS;
  localparam int unsigned PIPE_DEPTH  = GEOM_STAGES + DIV_STAGES + 1;

  // register port
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_OVERLAP_THRESHOLD = REG_IDX_W'(0);

  localparam logic [RATIO_W-1:0] RATIO_ONE     = {1'b1, {FRACTION_BITS{1'b0}}};
  // 0.1 in fixed point, rounded
  localparam logic [RATIO_W-1:0] THRESH_RESET  =
      RATIO_W'(((2 ** FRACTION_BITS) + 5) / 10);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_left;
    logic signed [COORD_BITS-1:0] a_top;
    logic signed [COORD_BITS-1:0] a_right;
    logic signed [COORD_BITS-1:0] a_bottom;
    logic signed [COORD_BITS-1:0] b_origin_x;
    logic signed [COORD_BITS-1:0] b_origin_y;
    logic        [COORD_BITS-2:0] b_width;
    logic        [COORD_BITS-2:0] b_height;
  } box_in_t;

  typedef struct packed {
    logic [RATIO_W-1:0] overlap_ratio;
    logic               above_threshold;
    logic               bad_union;
  } box_out_t;

  // geometry front end to divider
  typedef struct packed {
    logic              sep;   // boxes apart on an axis
    logic              bad;   // union not positive
    logic              sat;   // intersection >= union
    logic [PROD_W-1:0] num;
    logic [DEN_W-1:0]  den;
  } geom_t;

  // divider to output stage
  typedef struct packed {
    logic                     sep;
    logic                     bad;
    logic                     sat;
    logic [FRACTION_BITS-1:0] quot;
  } div_t;

endpackage

// File: rtl/bic_geom.sv
// bic_geom: five-stage front end; separation test, intersection and areas, union.
// Depends on bic_pkg.
module bic_geom (
  input  logic                                clk_i,
  input  logic [bic_pkg::GEOM_STAGES-1:0]     en_i,
  input  bic_pkg::box_in_t                    box_i,
  output bic_pkg::geom_t                      geom_o
);

  localparam int unsigned C      = bic_pkg::COORD_BITS;
  localparam int unsigned PROD_W = bic_pkg::PROD_W;
  localparam int unsigned AREA_W = bic_pkg::AREA_W;
  localparam int unsigned DEN_W  = bic_pkg::DEN_W;

  // ---- stage 1: far edges of B, separation, overlap edges, A size ----
  logic signed [C:0]   al_w, at_w, ar_w, ab_w, bx_w, by_w, bx2_w, by2_w;
  logic signed [C+1:0] aw_w, ah_w;
  logic                sep_w;

  assign al_w  = (C+1)'(box_i.a_left);
  assign at_w  = (C+1)'(box_i.a_top);
  assign ar_w  = (C+1)'(box_i.a_right);
  assign ab_w  = (C+1)'(box_i.a_bottom);
  assign bx_w  = (C+1)'(box_i.b_origin_x);
  assign by_w  = (C+1)'(box_i.b_origin_y);
  assign bx2_w = bx_w + $signed({2'b00, box_i.b_width});
  assign by2_w = by_w + $signed({2'b00, box_i.b_height});
  assign sep_w = (al_w > bx2_w) || (bx_w > ar_w) || (at_w > by2_w) || (by_w > ab_w);
  assign aw_w  = (C+2)'(ar_w) - (C+2)'(al_w) + (C+2)'(1);
  assign ah_w  = (C+2)'(ab_w) - (C+2)'(at_w) + (C+2)'(1);

  logic                sep1_q;
  logic signed [C:0]   xa1_q, ya1_q, xb1_q, yb1_q;
  logic signed [C+1:0] aw1_q, ah1_q;
  logic [C-1:0]        bw1_q, bh1_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sep1_q <= sep_w;
      xa1_q  <= (al_w > bx_w)  ? al_w : bx_w;
      ya1_q  <= (at_w > by_w)  ? at_w : by_w;
      xb1_q  <= (ar_w < bx2_w) ? ar_w : bx2_w;
      yb1_q  <= (ab_w < by2_w) ? ab_w : by2_w;
      aw1_q  <= aw_w;
      ah1_q  <= ah_w;
      bw1_q  <= {1'b0, box_i.b_width} + C'(1);
      bh1_q  <= {1'b0, box_i.b_height} + C'(1);
    end
  end

  // ---- stage 2: clamped intersection extents ----
  logic signed [C+1:0] dx_w, dy_w;
  assign dx_w = (C+2)'(xb1_q) - (C+2)'(xa1_q) + (C+2)'(1);
  assign dy_w = (C+2)'(yb1_q) - (C+2)'(ya1_q) + (C+2)'(1);

  logic                sep2_q;
  logic [C-1:0]        iw2_q, ih2_q, bw2_q, bh2_q;
  logic signed [C+1:0] aw2_q, ah2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sep2_q <= sep1_q;
      // inverted axis clamps to zero; otherwise width <= B size
      iw2_q  <= dx_w[C+1] ? '0 : dx_w[C-1:0];
      ih2_q  <= dy_w[C+1] ? '0 : dy_w[C-1:0];
      aw2_q  <= aw1_q;
      ah2_q  <= ah1_q;
      bw2_q  <= bw1_q;
      bh2_q  <= bh1_q;
    end
  end

  // ---- stage 3: the three products ----
  logic                     sep3_q;
  logic [PROD_W-1:0]        inter3_q, areab3_q;
  logic signed [AREA_W-1:0] areaa3_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      sep3_q   <= sep2_q;
      inter3_q <= iw2_q * ih2_q;
      areab3_q <= bw2_q * bh2_q;
      areaa3_q <= aw2_q * ah2_q;
    end
  end

  // ---- stage 4: union ----
  logic                     sep4_q;
  logic [PROD_W-1:0]        inter4_q;
  logic signed [AREA_W-1:0] uni4_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      sep4_q   <= sep3_q;
      inter4_q <= inter3_q;
      uni4_q   <= areaa3_q
                + $signed({{(AREA_W-PROD_W){1'b0}}, areab3_q})
                - $signed({{(AREA_W-PROD_W){1'b0}}, inter3_q});
    end
  end

  // ---- stage 5: classify, hand off to divider ----
  logic                     uni_bad_w;
  logic signed [AREA_W-1:0] inter_ext_w;
  assign uni_bad_w   = uni4_q[AREA_W-1] || (uni4_q == '0);
  assign inter_ext_w = $signed({{(AREA_W-PROD_W){1'b0}}, inter4_q});

  bic_pkg::geom_t geom5_q;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      geom5_q.sep <= sep4_q;
      geom5_q.bad <= !sep4_q && uni_bad_w;
      geom5_q.sat <= inter_ext_w >= uni4_q;
      geom5_q.num <= inter4_q;
      geom5_q.den <= uni4_q[DEN_W-1:0];
    end
  end

  assign geom_o = geom5_q;

endmodule

// File: rtl/bic_div.sv
// bic_div: pipelined restoring divider, one quotient bit per stage.
// Depends on bic_pkg.
module bic_div (
  input  logic                            clk_i,
  input  logic [bic_pkg::DIV_STAGES-1:0]  en_i,
  input  bic_pkg::geom_t                  geom_i,
  output bic_pkg::div_t                   res_o
);

  localparam int unsigned N      = bic_pkg::DIV_STAGES;
  localparam int unsigned F      = bic_pkg::FRACTION_BITS;
  localparam int unsigned DEN_W  = bic_pkg::DEN_W;
  localparam int unsigned PROD_W = bic_pkg::PROD_W;

  logic [DEN_W-1:0] rem_q  [N];
  logic [DEN_W-1:0] den_q  [N];
  logic [F-1:0]     quot_q [N];
  logic [N-1:0]     sep_q, bad_q, sat_q;

  logic [DEN_W-1:0] rem_in  [N];
  logic [DEN_W-1:0] den_in  [N];
  logic [F-1:0]     quot_in [N];
  logic [N-1:0]     sep_in, bad_in, sat_in;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           take;

    if (k == 0) begin : g_first
      assign rem_in[k]  = {{(DEN_W-PROD_W){1'b0}}, geom_i.num};
      assign den_in[k]  = geom_i.den;
      assign quot_in[k] = '0;
      assign sep_in[k]  = geom_i.sep;
      assign bad_in[k]  = geom_i.bad;
      assign sat_in[k]  = geom_i.sat;
    end else begin : g_next
      assign rem_in[k]  = rem_q[k-1];
      assign den_in[k]  = den_q[k-1];
      assign quot_in[k] = quot_q[k-1];
      assign sep_in[k]  = sep_q[k-1];
      assign bad_in[k]  = bad_q[k-1];
      assign sat_in[k]  = sat_q[k-1];
    end

    assign trial = {rem_in[k], 1'b0};
    assign take  = trial >= {1'b0, den_in[k]};

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k]  <= take ? DEN_W'(trial - {1'b0, den_in[k]}) : trial[DEN_W-1:0];
        den_q[k]  <= den_in[k];
        quot_q[k] <= {quot_in[k][F-2:0], take};
        sep_q[k]  <= sep_in[k];
        bad_q[k]  <= bad_in[k];
        sat_q[k]  <= sat_in[k];
      end
    end
  end

  assign res_o.sep  = sep_q[N-1];
  assign res_o.bad  = bad_q[N-1];
  assign res_o.sat  = sat_q[N-1];
  assign res_o.quot = quot_q[N-1];

endmodule

// File: rtl/box_iou_compare_unit.sv
// box_iou_compare_unit: intersection over union of two boxes with threshold flag.
// Depends on bic_pkg, bic_geom and bic_div.
//
//   channel   dir   handshake              payload
//   in        in    in_valid_i/in_stall_o  in_data_i   (bic_pkg::box_in_t)
//   out       out   out_valid_o/out_stall_i out_data_o (bic_pkg::box_out_t)
//   cfg       in    APB psel/penable/pready paddr/pwdata/prdata, threshold reg
//
// Throughput one item per cycle while out_stall_i is low; PIPE_DEPTH: five geometry
// stages (edges, extents, three products, union, classify), sixteen divider
// stages each doing one compare-subtract for one quotient bit, one output stage.
// Reset clears every stage valid and loads the threshold with 0.1 (6554).
// A held out_stall_i freezes the output register only; earlier stages keep
// closing bubbles, and in_stall_o rises once every stage holds an item.
module box_iou_compare_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // item in
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  bic_pkg::box_in_t                  in_data_i,
  // item out
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output bic_pkg::box_out_t                 out_data_o,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bic_pkg::ADDR_W-1:0]        paddr,
  input  logic [bic_pkg::DATA_W-1:0]        pwdata,
  output logic [bic_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  localparam int unsigned DEPTH   = bic_pkg::PIPE_DEPTH;
  localparam int unsigned GS      = bic_pkg::GEOM_STAGES;
  localparam int unsigned DS      = bic_pkg::DIV_STAGES;
  localparam int unsigned RATIO_W = bic_pkg::RATIO_W;
  localparam int unsigned DATA_W  = bic_pkg::DATA_W;
  localparam int unsigned ADDR_W  = bic_pkg::ADDR_W;

  // ---------------- threshold register ----------------
  logic [RATIO_W-1:0] thresh_q, thresh_d;
  logic               reg_hit;
  logic               reg_wr;

  assign reg_hit  = paddr[ADDR_W-1:2] == bic_pkg::REG_OVERLAP_THRESHOLD;
  assign reg_wr   = psel && penable && pwrite && pready && reg_hit;
  assign thresh_d = reg_wr ? pwdata[RATIO_W-1:0] : thresh_q;
  assign pready   = 1'b1;
  assign prdata   = reg_hit ? {{(DATA_W-RATIO_W){1'b0}}, thresh_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= bic_pkg::THRESH_RESET;
    end else begin
      thresh_q <= thresh_d;
    end
  end

  // ---------------- stage valids and advance chain ----------------
  // A stage loads when it is empty or the stage after it moves on, so bubbles
  // collapse while the output is stalled.
  logic [DEPTH-1:0] valid_q, valid_d, valid_in;
  logic [DEPTH:0]   adv;

  always_comb begin
    adv[DEPTH] = !out_stall_i;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign valid_in = {valid_q[DEPTH-2:0], in_valid_i};
  assign valid_d  = (adv[DEPTH-1:0] & valid_in) | (~adv[DEPTH-1:0] & valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = valid_q[DEPTH-1];

  // ---------------- datapath ----------------
  bic_pkg::geom_t geom;
  bic_pkg::div_t  div_res;

  bic_geom u_geom (
    .clk_i  (clk_i),
    .en_i   (adv[GS-1:0]),
    .box_i  (in_data_i),
    .geom_o (geom)
  );

  bic_div u_div (
    .clk_i  (clk_i),
    .en_i   (adv[GS+DS-1:GS]),
    .geom_i (geom),
    .res_o  (div_res)
  );

  // output stage: saturation, zero on separated or bad union, threshold compare
  logic [RATIO_W-1:0] ratio_w;
  logic               zero_w;
  bic_pkg::box_out_t  out_q, out_d;

  assign zero_w  = div_res.sep || div_res.bad;
  assign ratio_w = zero_w      ? '0 :
                   div_res.sat ? bic_pkg::RATIO_ONE :
                                 {1'b0, div_res.quot};

  always_comb begin
    out_d.overlap_ratio   = ratio_w;
    out_d.above_threshold = !zero_w && (ratio_w > thresh_q);
    out_d.bad_union       = div_res.bad;
  end

  always_ff @(posedge clk_i) begin
    if (adv[DEPTH-1]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  // ---------------- assertions ----------------
  a_bad_union_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.bad_union) |->
      (out_data_o.overlap_ratio == '0) && !out_data_o.above_threshold)
    else $error("bad union item carries nonzero ratio or flag");

  a_ratio_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.overlap_ratio <= bic_pkg::RATIO_ONE))
    else $error("ratio above 1.0");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&valid_q) && out_stall_i) |-> in_stall_o)
    else $error("input taken with full pipeline and stalled output");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[0])
    else $error("accepted item missing from first stage");

endmodule

// File: sim/tb_box_iou_compare_unit.sv
// Testbench for box_iou_compare_unit: directed box pairs, then random pairs under
// several threshold settings, each result checked against a typed-in result or a built-in predictor.
// Depends on bic_pkg and the box_iou_compare_unit RTL.
`timescale 1ns / 100ps

module tb_box_iou_compare_unit;

  localparam int unsigned COORD_BITS            = bic_pkg::COORD_BITS;
  localparam int unsigned FRACTION_BITS         = bic_pkg::FRACTION_BITS;
  localparam int unsigned RATIO_W               = bic_pkg::RATIO_W;
  localparam int unsigned ADDR_W                = bic_pkg::ADDR_W;
  localparam int unsigned DATA_W                = bic_pkg::DATA_W;
  localparam int unsigned PIPE_DEPTH            = bic_pkg::PIPE_DEPTH;
  localparam logic [RATIO_W-1:0] RATIO_ONE      = bic_pkg::RATIO_ONE;
  localparam logic [RATIO_W-1:0] THRESH_RESET   = bic_pkg::THRESH_RESET;

  typedef bic_pkg::box_in_t  box_in_t;
  typedef bic_pkg::box_out_t box_out_t;

  localparam int unsigned BOX_IN_W = $bits(box_in_t);

  localparam int CLK_HALF         = 5;
  localparam int RESET_CYCLES     = 4;
  localparam int DIRECTED_ROWS    = 18;
  localparam int RANDOM_PER_PHASE = 130;
  localparam int THRESH_PHASES    = 6;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int DRAIN_CYCLES     = PIPE_DEPTH + 8;

  // rows of the directed table reused as probes after each threshold change
  localparam int ROW_IDENTICAL = 0;
  localparam int ROW_CORNER    = 6;
  localparam int ROW_HALF      = 8;

  localparam logic [ADDR_W-1:0] THRESH_ADDR = {bic_pkg::REG_OVERLAP_THRESHOLD, 2'b00};

  // one directed row: the box pair and, where obvious, the result typed in
  typedef struct {
    box_in_t  boxes;
    bit       pinned;
    box_out_t pinned_out;
  } stim_row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  box_in_t           in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  box_out_t          out_data_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [ADDR_W-1:0] paddr       = '0;
  logic [DATA_W-1:0] pwdata      = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  box_out_t           overlap_expected[$];
  box_out_t           oldest_expected;
  logic [RATIO_W-1:0] threshold_setting = THRESH_RESET;
  stim_row_t          stim_table[DIRECTED_ROWS];
  int                 threshold_levels[THRESH_PHASES] = '{0, 65536, 32768, 32767, 0, 1};
  int                 mismatch_count = 0;
  int                 cycle_count    = 0;
  int                 tx_steady      = 0;
  int                 rx_steady      = 0;

  box_iou_compare_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Predicted IoU for one box pair. Box B's far edges sit at origin + size,
  // box A's edges are inclusive and used as given even when inverted.
  function automatic box_out_t predict_overlap(box_in_t b, logic [RATIO_W-1:0] thr);
    longint a_l, a_t, a_r, a_b, b_x, b_y, b_x2, b_y2;
    longint near_x, near_y, far_x, far_y, span_x, span_y;
    longint inter, area_a, area_b, union_area;
    box_out_t res;
    res    = '0;
    a_l    = longint'($signed(b.a_left));
    a_t    = longint'($signed(b.a_top));
    a_r    = longint'($signed(b.a_right));
    a_b    = longint'($signed(b.a_bottom));
    b_x    = longint'($signed(b.b_origin_x));
    b_y    = longint'($signed(b.b_origin_y));
    b_x2   = b_x + longint'(b.b_width);
    b_y2   = b_y + longint'(b.b_height);
    // apart on either axis: all-zero result
    if (a_l > b_x2 || b_x > a_r || a_t > b_y2 || b_y > a_b) begin
      return res;
    end
    near_x = (a_l > b_x) ? a_l : b_x;
    near_y = (a_t > b_y) ? a_t : b_y;
    far_x  = (a_r < b_x2) ? a_r : b_x2;
    far_y  = (a_b < b_y2) ? a_b : b_y2;
    span_x = far_x - near_x + 1;
    span_y = far_y - near_y + 1;
    if (span_x < 0) span_x = 0;
    if (span_y < 0) span_y = 0;
    inter      = span_x * span_y;
    area_a     = (a_r - a_l + 1) * (a_b - a_t + 1);
    area_b     = (longint'(b.b_width) + 1) * (longint'(b.b_height) + 1);
    union_area = area_a + area_b - inter;
    if (union_area <= 0) begin
      res.bad_union = 1'b1;
    end else if (inter >= union_area) begin
      res.overlap_ratio = RATIO_ONE;
    end else begin
      // at most 2^48 before the divide, no overflow in 64 bits
      res.overlap_ratio = RATIO_W'((inter << FRACTION_BITS) / union_area);
    end
    res.above_threshold = (res.overlap_ratio > thr);
    return res;
  endfunction

  // ratio < 0 leaves the row to the predictor
  function automatic stim_row_t stim_row(int l, int t, int r, int bt, int x, int y,
                                         int w, int h, int ratio = -1,
                                         bit above = 1'b0, bit bad = 1'b0);
    stim_row_t row;
    row.boxes.a_left                = COORD_BITS'(l);
    row.boxes.a_top                 = COORD_BITS'(t);
    row.boxes.a_right               = COORD_BITS'(r);
    row.boxes.a_bottom              = COORD_BITS'(bt);
    row.boxes.b_origin_x            = COORD_BITS'(x);
    row.boxes.b_origin_y            = COORD_BITS'(y);
    row.boxes.b_width               = (COORD_BITS-1)'(w);
    row.boxes.b_height              = (COORD_BITS-1)'(h);
    row.pinned                      = (ratio >= 0);
    row.pinned_out.overlap_ratio    = RATIO_W'(ratio);
    row.pinned_out.above_threshold  = above;
    row.pinned_out.bad_union        = bad;
    return row;
  endfunction

  // Directed table, run under the reset threshold (0.1).
  initial begin
    stim_table[0]  = stim_row(0, 0, 9, 9, 0, 0, 9, 9, RATIO_ONE, 1'b1);       // identical
    stim_table[1]  = stim_row(0, 0, 9, 9, 20, 0, 5, 5, 0);                    // apart in x
    stim_table[2]  = stim_row(0, 0, 9, 9, 0, 20, 5, 5, 0);                    // apart in y
    stim_table[3]  = stim_row(100, 0, 109, 9, 0, 0, 50, 9, 0);                // B left of A
    stim_table[4]  = stim_row(0, 0, 9, 9, 9, 9, 9, 9);                        // corner touch
    stim_table[5]  = stim_row(-32768, -32768, 32767, 32767,
                              -32768, -32768, 32767, 32767, 16384, 1'b1);    // full range
    stim_table[6]  = stim_row(32767, 32767, 32767, 32767,
                              32767, 32767, 32767, 32767, 0);                 // tiny vs huge
    stim_table[7]  = stim_row(0, 0, 0, 0, 0, 0, 0, 0, RATIO_ONE, 1'b1);       // one pixel
    stim_table[8]  = stim_row(0, 0, 1, 0, 0, 0, 0, 0, 32768, 1'b1);           // exactly half
    stim_table[9]  = stim_row(10, 0, 0, 99, 0, 0, 20, 0, 0, 1'b0, 1'b1);      // union < 0
    stim_table[10] = stim_row(2, 5, 0, 7, 0, 5, 2, 0, 0, 1'b0, 1'b1);         // union == 0
    stim_table[11] = stim_row(10, 10, 0, 0, 0, 0, 20, 20, 0);                 // A inverted both
    stim_table[12] = stim_row(-100, -100, 100, 100, -5, -5, 10, 10);          // B inside A
    stim_table[13] = stim_row(0, 0, 3, 3, -2, -2, 30, 30);                    // A inside B
    stim_table[14] = stim_row(-32768, -32768, -32768, -32768,
                              -32768, -32768, 0, 0, RATIO_ONE, 1'b1);         // min corner
    stim_table[15] = stim_row(-1, -1, -1, -1, -1, -1, 32767, 32767, 0);       // all ones
    stim_table[16] = stim_row(0, 50, 9, 0, 0, 0, 9, 60);                      // A inverted in y
    stim_table[17] = stim_row(0, 0, 99, 99, 0, 0, 99, 98);                    // just below 1.0
  end

  // Wait length per item: mostly a uniform random draw, with runs of back-to-back items.
  function automatic int draw_wait(inout int steady);
    if (steady > 0) begin
      steady--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      steady = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // Random box pair. Most pairs overlap so the divider sees real work;
  // the rest are near-identical, inverted, large, raw noise or apart.
  function automatic box_in_t random_boxes();
    box_in_t b;
    int kind, x0, y0, wa, ha, wb, hb, dx, dy, tmp;
    kind = $urandom_range(0, 99);
    x0   = int'($urandom_range(0, 65535)) - 32768;
    y0   = int'($urandom_range(0, 65535)) - 32768;
    wa   = $urandom_range(0, 63);
    ha   = $urandom_range(0, 63);
    wb   = $urandom_range(0, 63);
    hb   = $urandom_range(0, 63);
    dx   = int'($urandom_range(0, 64)) - 32;
    dy   = int'($urandom_range(0, 64)) - 32;
    if (kind >= 55 && kind < 67) begin
      // near-identical pair, ratio close to 1.0
      dx = int'($urandom_range(0, 2)) - 1;
      dy = int'($urandom_range(0, 2)) - 1;
      wb = wa + int'($urandom_range(0, 2)) - 1;
      hb = ha + int'($urandom_range(0, 2)) - 1;
      if (wb < 0) wb = 0;
      if (hb < 0) hb = 0;
    end else if (kind >= 87 && kind < 94) begin
      // large boxes, upper bits of the sizes
      x0 = int'($urandom_range(0, 32767)) - 32768;
      y0 = int'($urandom_range(0, 32767)) - 32768;
      wa = $urandom_range(0, 65535);
      ha = $urandom_range(0, 65535);
      wb = $urandom_range(16384, 32767);
      hb = $urandom_range(16384, 32767);
      dx = $urandom_range(0, wa);
      dy = $urandom_range(0, ha);
    end else if (kind >= 94) begin
      // pushed clear of A on one axis
      if ($urandom_range(0, 1)) dx = wa + 1 + int'($urandom_range(0, 1000));
      else dy = -(hb + 1 + int'($urandom_range(0, 1000)));
    end
    b.a_left     = COORD_BITS'(x0);
    b.a_top      = COORD_BITS'(y0);
    b.a_right    = COORD_BITS'(x0 + wa);
    b.a_bottom   = COORD_BITS'(y0 + ha);
    b.b_origin_x = COORD_BITS'(x0 + dx);
    b.b_origin_y = COORD_BITS'(y0 + dy);
    b.b_width    = (COORD_BITS-1)'(wb);
    b.b_height   = (COORD_BITS-1)'(hb);
    if (kind >= 67 && kind < 77) begin
      // inverted A on one or both axes, or on neither
      if ($urandom_range(0, 2) != 0) begin
        tmp = b.a_left;
        b.a_left  = b.a_right;
        b.a_right = COORD_BITS'(tmp);
      end
      if ($urandom_range(0, 2) != 1) begin
        tmp = b.a_top;
        b.a_top    = b.a_bottom;
        b.a_bottom = COORD_BITS'(tmp);
      end
    end else if (kind >= 77 && kind < 87) begin
      // raw noise over every field
      b = BOX_IN_W'({$urandom, $urandom, $urandom, $urandom});
    end
    return b;
  endfunction

  // Present one item after a random gap and hold it until accepted.
  // The expectation is queued at the accepting edge with the live threshold.
  task automatic send_box(box_in_t b, bit pinned, box_out_t pinned_out);
    int       gap;
    box_out_t due;
    gap = draw_wait(tx_steady);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    due = pinned ? pinned_out : predict_overlap(b, threshold_setting);
    overlap_expected = {overlap_expected, due};
  endtask

  // Drop valid and wait until every queued result has come back.
  task automatic hold_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (overlap_expected.size() != 0) @(posedge clk_i);
  endtask

  task automatic read_threshold(output logic [DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= THRESH_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    value = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_threshold_readback();
    logic [DATA_W-1:0] value;
    read_threshold(value);
    if (value !== DATA_W'(threshold_setting)) begin
      $display("%0t: threshold readback expected %0d actual %0d",
               $time, threshold_setting, value);
      mismatch_count++;
    end
  endtask

  // APB write: setup cycle, then access cycle; register loads when pready is high.
  task automatic program_threshold(logic [RATIO_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= THRESH_ADDR;
    pwdata  <= DATA_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    threshold_setting = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_threshold_readback();
  endtask

  // Output side: stall a random number of cycles per item, then take one.
  initial begin
    int stall_cycles;
    @(posedge rst_ni);
    forever begin
      stall_cycles = draw_wait(rx_steady);
      if (stall_cycles > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (stall_cycles) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Every accepted result against the oldest expectation, field by field.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (overlap_expected.size() == 0) begin
        $display("%0t: result with none expected: ratio %0d above %0b bad %0b", $time,
                 out_data_o.overlap_ratio, out_data_o.above_threshold,
                 out_data_o.bad_union);
        mismatch_count++;
      end else begin
        oldest_expected = overlap_expected.pop_front();
        if (out_data_o.overlap_ratio !== oldest_expected.overlap_ratio) begin
          $display("%0t: overlap_ratio expected %0d actual %0d", $time,
                   oldest_expected.overlap_ratio, out_data_o.overlap_ratio);
          mismatch_count++;
        end
        if (out_data_o.above_threshold !== oldest_expected.above_threshold) begin
          $display("%0t: above_threshold expected %0b actual %0b", $time,
                   oldest_expected.above_threshold, out_data_o.above_threshold);
          mismatch_count++;
        end
        if (out_data_o.bad_union !== oldest_expected.bad_union) begin
          $display("%0t: bad_union expected %0b actual %0b", $time,
                   oldest_expected.bad_union, out_data_o.bad_union);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog, roughly ten times the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("box_iou_compare_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int row, n, phase;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset value of the threshold (0.1)
    check_threshold_readback();

    for (row = 0; row < DIRECTED_ROWS; row++) begin
      send_box(stim_table[row].boxes, stim_table[row].pinned, stim_table[row].pinned_out);
    end

    // random at the reset threshold, with one full drain partway through
    for (n = 0; n < RANDOM_PER_PHASE; n++) begin
      if (n == RANDOM_PER_PHASE / 2) hold_until_drained();
      send_box(random_boxes(), 1'b0, '0);
    end

    // Threshold sweep: zero, 1.0, exactly the half ratio and one below it,
    // a random level and the smallest step. Writes only with the pipe empty.
    threshold_levels[4] = $urandom_range(1, 65535);
    for (phase = 0; phase < THRESH_PHASES; phase++) begin
      hold_until_drained();
      program_threshold(RATIO_W'(threshold_levels[phase]));
      // probes land on ratios 1.0, 0.5 and 0 around the new level
      send_box(stim_table[ROW_IDENTICAL].boxes, 1'b0, '0);
      send_box(stim_table[ROW_HALF].boxes, 1'b0, '0);
      send_box(stim_table[ROW_CORNER].boxes, 1'b0, '0);
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_box(random_boxes(), 1'b0, '0);
      end
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("box_iou_compare_unit regression: pass");
    end else begin
      $display("box_iou_compare_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/bic_pkg.sv
rtl/bic_geom.sv
rtl/bic_div.sv
rtl/box_iou_compare_unit.sv
sim/tb_box_iou_compare_unit.sv
